FILE: design/mpfr_pkg.sv
// shared constants and types of the multi-protocol frame receiver
// no dependencies; used by the top, framer and store through mpfr_pkg:: names
`timescale 1ns / 1ps
`default_nettype none

package mpfr_pkg;

  // default depth of the frame store
  localparam int BUFFER_SIZE_DEF = 64;

  // marker bytes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // bytes looked at by the modbus end check, and length of a tilde frame
  localparam int MODBUS_TAIL_LEN = 2;
  localparam int TILDE_FRAME_LEN = 4;

  typedef enum logic [2:0] {
    P_MODBUS = 3'd0,
    P_HASH   = 3'd1,
    P_CR     = 3'd2,
    P_TILDE  = 3'd3,
    P_ECHO   = 3'd4
  } proto_t;

  // framer to store: what happens with the accepted item
  typedef struct packed {
    logic wr_en;
    logic emit;
    logic echo;
  } ctl_t;

  // store to top: readout status
  typedef struct packed {
    logic busy;
    logic idle;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/multi_protocol_frame_receiver_top.sv
// channel   | handshake          | payload
// ----------+--------------------+-----------------------------------
// input     | in_valid/in_stall  | in_rx_byte[7:0]
// result    | out_valid/out_stall| out_byte[7:0], out_kind, out_last
// config    | cfg_valid/cfg_ready| cfg_protocol[2:0]
//
// a byte that completes no frame, or an echoed byte, starts no readout from the store
// a completed frame of n bytes is read from the store at one byte a cycle
// while the output queue has room, through a read register; in_stall stays
// high until the last byte read has reached the output queue and the queue
// has room
// rst_n clears protocol, fill position and queue; the store is not cleared,
// readout only covers positions written since the frame began
// cfg_ready is high only when nothing is pending on the result side
// depends on mpfr_pkg, mpfr_frame, mpfr_store
`timescale 1ns / 1ps
`default_nettype none

module multi_protocol_frame_receiver_top #(
  parameter int BUFFER_SIZE = mpfr_pkg::BUFFER_SIZE_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_rx_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_byte,
  output logic       out_kind,
  output logic       out_last,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [2:0] cfg_protocol
);

  localparam int AW = $clog2(BUFFER_SIZE);
  localparam int CW = $clog2(BUFFER_SIZE + 1);

  mpfr_pkg::ctl_t ctl;
  mpfr_pkg::sts_t sts;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic [CW-1:0]  emit_len;
  logic           in_fire;
  logic           cfg_fire;

  assign in_stall  = sts.busy;
  assign cfg_ready = sts.idle;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_fire  = cfg_valid && cfg_ready;

  mpfr_frame #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .rx_byte  (in_rx_byte),
    .cfg_fire (cfg_fire),
    .cfg_data (cfg_protocol),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .emit_len (emit_len)
  );

  mpfr_store #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .emit_len  (emit_len),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last),
    .sts       (sts)
  );

endmodule

`default_nettype wire

FILE: design/mpfr_frame.sv
// framing decisions: protocol register, fill position, shadow copies of the
// bytes the end checks look at; drives the store's write and readout start
// depends on mpfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module mpfr_frame #(
  parameter int BUFFER_SIZE = mpfr_pkg::BUFFER_SIZE_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_fire,
  input  wire  [7:0]                          rx_byte,
  input  wire                                 cfg_fire,
  input  wire  [2:0]                          cfg_data,
  output mpfr_pkg::ctl_t                      ctl,
  output logic [$clog2(BUFFER_SIZE)-1:0]      wr_addr,
  output logic [7:0]                          wr_data,
  output logic [$clog2(BUFFER_SIZE+1)-1:0]    emit_len
);

  localparam int AW = $clog2(BUFFER_SIZE);
  localparam int CW = $clog2(BUFFER_SIZE + 1);

  mpfr_pkg::proto_t protocol_r;
  logic [CW-1:0]    fp_r, fp_nxt;
  // first byte, last byte and the one before it, mirrors of the store
  logic [7:0]       first_r, first_nxt;
  logic [7:0]       last_r, last_nxt;
  logic [7:0]       prev_r, prev_nxt;

  logic             put;
  logic             framed;
  logic             done;
  logic [CW-1:0]    base;
  logic [CW-1:0]    fp_new;

  always_comb begin
    put    = 1'b0;
    framed = 1'b1;
    base   = fp_r;
    case (protocol_r)
      mpfr_pkg::P_MODBUS: begin
        if (rx_byte == mpfr_pkg::CH_COLON) begin
          put  = 1'b1;
          base = '0;
        end else begin
          put = (fp_r != '0);
        end
      end
      mpfr_pkg::P_HASH: begin
        if (rx_byte == mpfr_pkg::CH_HASH) begin
          put  = 1'b1;
          base = '0;
        end else begin
          put = (fp_r != '0);
        end
      end
      mpfr_pkg::P_CR: begin
        put = (rx_byte != mpfr_pkg::CH_GT) && (rx_byte != mpfr_pkg::CH_LF);
      end
      mpfr_pkg::P_TILDE: begin
        put = ((rx_byte == mpfr_pkg::CH_TILDE) && (fp_r == '0)) ||
              ((fp_r != '0) && (fp_r < CW'(mpfr_pkg::TILDE_FRAME_LEN)));
      end
      default: begin
        framed = 1'b0;
      end
    endcase
  end

  always_comb begin
    fp_new    = put ? (base + CW'(1)) : fp_r;
    last_nxt  = put ? rx_byte : last_r;
    prev_nxt  = put ? last_r : prev_r;
    first_nxt = (put && (base == '0)) ? rx_byte : first_r;
  end

  always_comb begin
    case (protocol_r)
      mpfr_pkg::P_MODBUS: begin
        done = (fp_new >= CW'(mpfr_pkg::MODBUS_TAIL_LEN)) &&
               (first_nxt == mpfr_pkg::CH_COLON) &&
               (prev_nxt == mpfr_pkg::CH_CR) && (last_nxt == mpfr_pkg::CH_LF);
      end
      mpfr_pkg::P_HASH: begin
        done = (fp_new != '0) && (first_nxt == mpfr_pkg::CH_HASH) &&
               (last_nxt == mpfr_pkg::CH_CR);
      end
      mpfr_pkg::P_CR: begin
        done = (fp_new != '0) && (last_nxt == mpfr_pkg::CH_CR);
      end
      mpfr_pkg::P_TILDE: begin
        done = (first_nxt == mpfr_pkg::CH_TILDE) &&
               (fp_new == CW'(mpfr_pkg::TILDE_FRAME_LEN));
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_comb begin
    fp_nxt = fp_r;
    if (in_fire && framed) begin
      // a full store with no frame end drops the frame
      if (done || (fp_new >= CW'(BUFFER_SIZE))) begin
        fp_nxt = '0;
      end else begin
        fp_nxt = fp_new;
      end
    end
  end

  assign ctl.wr_en = in_fire && put;
  assign ctl.emit  = in_fire && framed && done;
  assign ctl.echo  = in_fire && (protocol_r == mpfr_pkg::P_ECHO);
  assign wr_addr   = base[AW-1:0];
  assign wr_data   = rx_byte;
  assign emit_len  = fp_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_r <= mpfr_pkg::P_MODBUS;
      fp_r       <= '0;
      first_r    <= '0;
      last_r     <= '0;
      prev_r     <= '0;
    end else begin
      if (cfg_fire) begin
        protocol_r <= mpfr_pkg::proto_t'(cfg_data);
      end
      fp_r <= fp_nxt;
      if (in_fire) begin
        first_r <= first_nxt;
        last_r  <= last_nxt;
        prev_r  <= prev_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/mpfr_store.sv
// frame store memory with its readout sequencer and a two-entry output queue
// depends on mpfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module mpfr_store #(
  parameter int BUFFER_SIZE = mpfr_pkg::BUFFER_SIZE_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  mpfr_pkg::ctl_t                ctl,
  input  wire  [$clog2(BUFFER_SIZE)-1:0]      wr_addr,
  input  wire  [7:0]                          wr_data,
  input  wire  [$clog2(BUFFER_SIZE+1)-1:0]    emit_len,
  input  wire                                 out_stall,
  output logic                                out_valid,
  output logic [7:0]                          out_byte,
  output logic                                out_kind,
  output logic                                out_last,
  output mpfr_pkg::sts_t                      sts
);

  localparam int AW = $clog2(BUFFER_SIZE);
  localparam int CW = $clog2(BUFFER_SIZE + 1);

  logic [7:0]    mem [BUFFER_SIZE];
  logic [7:0]    rd_data_r;

  logic [CW-1:0] rem_r, rem_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          inflight_r;
  logic          inflight_last_r;

  logic [7:0]    q_byte_r [2];
  logic          q_kind_r [2];
  logic          q_last_r [2];
  logic          wptr_r, rptr_r;
  logic [1:0]    cnt_r, cnt_nxt;

  logic          pop, push, issue;
  logic [1:0]    occ;
  logic [7:0]    push_byte;
  logic          push_kind, push_last;

  assign pop = (cnt_r != 2'd0) && !out_stall;
  // queue entries plus the read in flight
  assign occ   = cnt_r + {1'b0, inflight_r};
  assign issue = (rem_r != '0) && ((occ < 2'd2) || pop);

  assign push      = inflight_r || ctl.echo;
  assign push_byte = inflight_r ? rd_data_r : wr_data;
  assign push_kind = !inflight_r;
  assign push_last = inflight_r ? inflight_last_r : 1'b1;

  always_comb begin
    rem_nxt     = rem_r;
    rd_addr_nxt = rd_addr_r;
    if (ctl.emit) begin
      rem_nxt     = emit_len;
      rd_addr_nxt = '0;
    end else if (issue) begin
      rem_nxt     = rem_r - CW'(1);
      rd_addr_nxt = rd_addr_r + AW'(1);
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_byte_r[wptr_r] <= push_byte;
      q_kind_r[wptr_r] <= push_kind;
      q_last_r[wptr_r] <= push_last;
    end
    if (issue) begin
      inflight_last_r <= (rem_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r      <= '0;
      rd_addr_r  <= '0;
      inflight_r <= 1'b0;
      wptr_r     <= 1'b0;
      rptr_r     <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      rem_r      <= rem_nxt;
      rd_addr_r  <= rd_addr_nxt;
      inflight_r <= issue;
      cnt_r      <= cnt_nxt;
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_byte  = q_byte_r[rptr_r];
  assign out_kind  = q_kind_r[rptr_r];
  assign out_last  = q_last_r[rptr_r];

  assign sts.busy = (rem_r != '0) || inflight_r || (cnt_r == 2'd2);
  assign sts.idle = (rem_r == '0) && !inflight_r && (cnt_r == 2'd0);

endmodule

`default_nettype wire

FILE: design/mpfr_checker.sv
// port-level checks of the frame receiver, attached by bind
// depends on multi_protocol_frame_receiver_top
`timescale 1ns / 1ps
`default_nettype none

module mpfr_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire [7:0] out_byte,
  input wire       out_kind,
  input wire       out_last,
  input wire       cfg_ready
);

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_byte) && $stable(out_kind) &&
                               $stable(out_last))
    else $error("result item changed while stalled");

  // an echoed item always closes itself
  a_echo_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last)
    else $error("echoed item without last");

  // configuration is offered only with nothing left on the result side
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !out_valid && !in_stall)
    else $error("configuration ready while results pending");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result item present right after reset");

endmodule

bind multi_protocol_frame_receiver_top mpfr_checker u_mpfr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_byte     (out_byte),
  .out_kind     (out_kind),
  .out_last     (out_last),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for multi_protocol_frame_receiver_top: directed bytes per protocol,
// then random frames, noise and long frames, each result checked against a frame predictor or a stated item
// depends on mpfr_pkg and the design files under design/

module testbench;

  localparam int DEPTH = mpfr_pkg::BUFFER_SIZE_DEF;
  localparam int MAX_GAP = 13;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES = DEPTH + 16;
  localparam int DRAIN_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 40;
  localparam int MAX_PRINTS = 40;

  // protocol codes the block does not use
  localparam logic [2:0] P_SPARE_LO = 3'd5;
  localparam logic [2:0] P_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       last;
  } rx_result_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } row_check_t;

  typedef struct packed {
    logic [2:0] proto;
    logic [7:0] rx;
    row_check_t chk;
    rx_result_t want;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_kind;
  logic       out_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_protocol;

  multi_protocol_frame_receiver_top #(
    .BUFFER_SIZE(DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_kind(out_kind),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_protocol(cfg_protocol)
  );

  // framer state as the block should hold it
  logic [2:0] frame_proto;
  logic [7:0] frame_store [DEPTH];
  logic [6:0] frame_fill;

  rx_result_t expected_q [$];
  rx_result_t frame_bytes [$];
  stim_row_t  directed_rows [$];

  int  errors;
  int  items_sent;
  int  results_seen;
  int  frames_done;
  int  drops;
  int  cfg_writes;
  bit  calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("run timed out, %0d items still expected", expected_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic void store_byte(input logic [7:0] b);
    if (frame_fill >= DEPTH) frame_fill = '0;
    frame_store[frame_fill] = b;
    frame_fill = frame_fill + 1'b1;
  endfunction

  // leaves in frame_bytes the result items caused by one received byte
  function automatic void predict_rx(input logic [7:0] b);
    logic       done;
    logic       framed;
    rx_result_t r;
    int         k;
    done = 1'b0;
    framed = 1'b1;
    frame_bytes.delete();
    case (frame_proto)
      mpfr_pkg::P_MODBUS: begin
        if (b == mpfr_pkg::CH_COLON) begin
          frame_fill = '0;
          store_byte(b);
        end else if (frame_fill != 0) begin
          store_byte(b);
        end
        if (frame_fill >= mpfr_pkg::MODBUS_TAIL_LEN)
          done = frame_store[0] == mpfr_pkg::CH_COLON &&
                 frame_store[frame_fill - 2] == mpfr_pkg::CH_CR &&
                 frame_store[frame_fill - 1] == mpfr_pkg::CH_LF;
      end
      mpfr_pkg::P_HASH: begin
        if (b == mpfr_pkg::CH_HASH) begin
          frame_fill = '0;
          store_byte(b);
        end else if (frame_fill != 0) begin
          store_byte(b);
        end
        if (frame_fill >= 1)
          done = frame_store[0] == mpfr_pkg::CH_HASH &&
                 frame_store[frame_fill - 1] == mpfr_pkg::CH_CR;
      end
      mpfr_pkg::P_CR: begin
        if (b != mpfr_pkg::CH_GT && b != mpfr_pkg::CH_LF) store_byte(b);
        if (frame_fill >= 1) done = frame_store[frame_fill - 1] == mpfr_pkg::CH_CR;
      end
      mpfr_pkg::P_TILDE: begin
        if (b == mpfr_pkg::CH_TILDE && frame_fill == 0) store_byte(b);
        else if (frame_fill > 0 && frame_fill < mpfr_pkg::TILDE_FRAME_LEN) store_byte(b);
        done = frame_store[0] == mpfr_pkg::CH_TILDE &&
               frame_fill == mpfr_pkg::TILDE_FRAME_LEN;
      end
      mpfr_pkg::P_ECHO: begin
        framed = 1'b0;
        r.data = b;
        r.kind = 1'b1;
        r.last = 1'b1;
        frame_bytes.push_back(r);
      end
      default: framed = 1'b0;
    endcase
    if (framed) begin
      if (done) begin
        for (k = 0; k < frame_fill; k++) begin
          r.data = frame_store[k];
          r.kind = 1'b0;
          r.last = (k == frame_fill - 1);
          frame_bytes.push_back(r);
        end
        frame_fill = '0;
        frames_done++;
      end else if (frame_fill >= DEPTH) begin
        // store full with no end: frame dropped
        frame_fill = '0;
        drops++;
      end
    end
  endfunction

  // called at a rising edge, returns at the edge that takes the item
  task automatic send_item(input logic [7:0] b, input row_check_t chk, input rx_result_t want);
    int gap;
    int k;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_rx(b);
    case (chk)
      CHK_MODEL: for (k = 0; k < frame_bytes.size(); k++) expected_q.push_back(frame_bytes[k]);
      CHK_ONE: expected_q.push_back(want);
      default: ;
    endcase
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    items_sent++;
  endtask

  // only once the result side has drained and the block has settled
  task automatic write_protocol(input logic [2:0] p);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_protocol <= p;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    frame_proto = p;
    cfg_writes++;
  endtask

  function automatic logic [7:0] body_byte(input logic [7:0] skip_a, input logic [7:0] skip_b,
                                           input logic [7:0] skip_c);
    logic [7:0] r;
    do r = 8'($urandom_range(0, 255)); while (r == skip_a || r == skip_b || r == skip_c);
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] p, input logic [7:0] b, input row_check_t chk,
                                  input logic [7:0] d, input logic kd, input logic lt);
    stim_row_t row;
    row.proto = p;
    row.rx = b;
    row.chk = chk;
    row.want.data = d;
    row.want.kind = kd;
    row.want.last = lt;
    directed_rows.push_back(row);
  endfunction

  // one well-formed frame with random content, now and then broken, or random bytes unframed
  task automatic send_frame(input logic [2:0] p);
    int body_len;
    bit broken;
    body_len = $urandom_range(0, 6);
    broken = ($urandom_range(0, 4) == 0);
    case (p)
      mpfr_pkg::P_MODBUS: begin
        send_item(mpfr_pkg::CH_COLON, CHK_MODEL, '0);
        repeat (body_len)
          send_item(body_byte(mpfr_pkg::CH_COLON, mpfr_pkg::CH_CR, mpfr_pkg::CH_CR),
                    CHK_MODEL, '0);
        send_item(mpfr_pkg::CH_CR, CHK_MODEL, '0);
        send_item(broken ? body_byte(mpfr_pkg::CH_LF, mpfr_pkg::CH_LF, mpfr_pkg::CH_LF)
                         : mpfr_pkg::CH_LF, CHK_MODEL, '0);
      end
      mpfr_pkg::P_HASH: begin
        send_item(mpfr_pkg::CH_HASH, CHK_MODEL, '0);
        repeat (body_len)
          send_item(body_byte(mpfr_pkg::CH_HASH, mpfr_pkg::CH_CR, mpfr_pkg::CH_CR),
                    CHK_MODEL, '0);
        send_item(broken ? body_byte(mpfr_pkg::CH_CR, mpfr_pkg::CH_CR, mpfr_pkg::CH_CR)
                         : mpfr_pkg::CH_CR, CHK_MODEL, '0);
      end
      mpfr_pkg::P_CR: begin
        repeat (body_len) begin
          if ($urandom_range(0, 5) == 0)
            send_item($urandom_range(0, 1) ? mpfr_pkg::CH_GT : mpfr_pkg::CH_LF,
                      CHK_MODEL, '0);
          send_item(body_byte(mpfr_pkg::CH_CR, mpfr_pkg::CH_CR, mpfr_pkg::CH_CR),
                    CHK_MODEL, '0);
        end
        if (!broken) send_item(mpfr_pkg::CH_CR, CHK_MODEL, '0);
      end
      mpfr_pkg::P_TILDE: begin
        send_item(broken ? body_byte(mpfr_pkg::CH_TILDE, mpfr_pkg::CH_TILDE,
                                     mpfr_pkg::CH_TILDE)
                         : mpfr_pkg::CH_TILDE, CHK_MODEL, '0);
        repeat (mpfr_pkg::TILDE_FRAME_LEN - 1)
          send_item(8'($urandom_range(0, 255)), CHK_MODEL, '0);
      end
      default: repeat (body_len + 1) send_item(8'($urandom_range(0, 255)), CHK_MODEL, '0);
    endcase
  endtask

  initial begin : result_sink
    int gap;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  // valid and stall only move at rising edges, so the falling edge shows the coming handshake
  always @(negedge clk) begin : check_results
    rx_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item byte %h kind %b last %b",
                                  out_byte, out_kind, out_last));
      end else begin
        want = expected_q.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("byte %h, expected %h", out_byte, want.data));
        if (out_kind !== want.kind)
          report_mismatch($sformatf("kind %b, expected %b (byte %h)", out_kind, want.kind,
                                    want.data));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, expected %b (byte %h)", out_last, want.last,
                                    want.data));
      end
    end
  end

  initial begin : stimulus
    int k;
    int wait_cycles;
    int random_end;
    logic [2:0] p;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_protocol <= mpfr_pkg::P_MODBUS;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    frames_done = 0;
    drops = 0;
    cfg_writes = 0;
    calm = 1'b0;
    frame_proto = mpfr_pkg::P_MODBUS;
    frame_fill = '0;
    for (k = 0; k < DEPTH; k++) frame_store[k] = 8'h00;

    // echo, unused codes, lone end bytes and one short frame per framed protocol
    add_row(mpfr_pkg::P_ECHO, 8'h00, CHK_ONE, 8'h00, 1'b1, 1'b1);
    add_row(mpfr_pkg::P_ECHO, 8'hFF, CHK_ONE, 8'hFF, 1'b1, 1'b1);
    add_row(P_SPARE_HI, 8'h55, CHK_NONE, 8'h00, 1'b0, 1'b0);
    add_row(P_SPARE_LO, 8'hAA, CHK_NONE, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_MODBUS, mpfr_pkg::CH_CR, CHK_NONE, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_MODBUS, mpfr_pkg::CH_LF, CHK_NONE, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_MODBUS, mpfr_pkg::CH_COLON, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_MODBUS, mpfr_pkg::CH_CR, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_MODBUS, mpfr_pkg::CH_LF, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_HASH, mpfr_pkg::CH_CR, CHK_NONE, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_HASH, mpfr_pkg::CH_HASH, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_HASH, 8'h41, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_HASH, mpfr_pkg::CH_CR, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_CR, mpfr_pkg::CH_CR, CHK_ONE, mpfr_pkg::CH_CR, 1'b0, 1'b1);
    add_row(mpfr_pkg::P_CR, mpfr_pkg::CH_GT, CHK_NONE, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_CR, 8'h78, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_CR, mpfr_pkg::CH_LF, CHK_NONE, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_CR, mpfr_pkg::CH_CR, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_TILDE, mpfr_pkg::CH_TILDE, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_TILDE, 8'h01, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_TILDE, 8'h02, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_TILDE, 8'h03, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    // protocol switch with a partial frame held, tilde mode then stuck at four bytes
    add_row(mpfr_pkg::P_CR, 8'h61, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_CR, 8'h62, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_TILDE, mpfr_pkg::CH_TILDE, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_TILDE, 8'h80, CHK_MODEL, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_TILDE, 8'h7F, CHK_NONE, 8'h00, 1'b0, 1'b0);
    add_row(mpfr_pkg::P_CR, mpfr_pkg::CH_CR, CHK_MODEL, 8'h00, 1'b0, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < directed_rows.size(); k++) begin
      if (directed_rows[k].proto != frame_proto) write_protocol(directed_rows[k].proto);
      send_item(directed_rows[k].rx, directed_rows[k].chk, directed_rows[k].want);
    end

    random_end = items_sent + RANDOM_ITEMS;
    while (items_sent < random_end) begin
      if ($urandom_range(0, 15) == 0) p = 3'($urandom_range(P_SPARE_LO, P_SPARE_HI));
      else p = 3'($urandom_range(mpfr_pkg::P_MODBUS, mpfr_pkg::P_ECHO));
      calm = ($urandom_range(0, 3) == 0);
      write_protocol(p);
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 4) == 0) send_item(8'($urandom_range(0, 255)), CHK_MODEL, '0);
        send_frame(p);
      end
    end

    // a one-byte frame, a full-size frame, then a store overflow followed by a short frame
    calm = 1'b0;
    write_protocol(mpfr_pkg::P_CR);
    send_item(mpfr_pkg::CH_CR, CHK_MODEL, '0);
    repeat (DEPTH - 1)
      send_item(body_byte(mpfr_pkg::CH_CR, mpfr_pkg::CH_GT, mpfr_pkg::CH_LF), CHK_MODEL, '0);
    send_item(mpfr_pkg::CH_CR, CHK_MODEL, '0);
    repeat (DEPTH + 6)
      send_item(body_byte(mpfr_pkg::CH_CR, mpfr_pkg::CH_GT, mpfr_pkg::CH_LF), CHK_MODEL, '0);
    send_item(mpfr_pkg::CH_CR, CHK_MODEL, '0);

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (END_CYCLES) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d expected items never came out", expected_q.size()));

    $display("sent %0d bytes under %0d protocol writes: %0d frames completed, %0d dropped full",
             items_sent, cfg_writes, frames_done, drops);
    $display("checked %0d result items, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
